// ===== rtl/cstk_pkg.sv =====
// Shared types for the C subset token scanner: token kinds, the token
// record and the bundle that carries up to two new tokens to the queue.
// No dependencies.
`default_nettype none

package cstk_pkg;

    // Token kinds, in the order of the result encoding.
    typedef enum logic [4:0] {
        K_EOF,
        K_PREPROC,
        K_INT,
        K_FLOAT,
        K_CHAR,
        K_IDENT,
        K_NUMBER,
        K_CHARCONST,
        K_STRING,
        K_ASSIGN,
        K_SEMI,
        K_COMMA,
        K_LPAREN,
        K_RPAREN,
        K_LBRACE,
        K_RBRACE,
        K_PLUS,
        K_MINUS,
        K_STAR,
        K_SLASH,
        K_UNKNOWN
    } tok_kind_t;

    // One finished token as it leaves the block.
    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] line;
        logic [15:0] offset;
        logic [6:0]  length;
        logic        last;
    } tok_t;

    // Tokens produced by one accepted word: count, then first and second.
    typedef struct packed {
        logic [1:0] count;
        tok_t       first;
        tok_t       second;
    } tok_push_t;

endpackage

`default_nettype wire

// ===== rtl/c_subset_token_scanner_core.sv =====
// A token is written into the token queue when the word that completes it is
// taken, and is offered once the tokens ahead of it drain. Throughput: one
// source word per cycle while results drain; a word yields at most two tokens
// and the four-entry token queue takes input whenever at least two entries are free.
// Reset (aresetn low, synchronous): scanner returns to idle at line 1,
// offset 0, and the token queue empties.
`default_nettype none

module c_subset_token_scanner_core
    import cstk_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 16,
    parameter int MAX_TEXT    = 127
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Source side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] source_byte
    input  wire logic        s_tuser,   // [0] end_of_source
    // Token side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [4:0] token_kind, [20:5] token_line,
                                        // [36:21] token_offset, [43:37] token_length
    output logic             m_tlast    // last_of_run
);

    tok_push_t push;
    tok_t      head;
    logic      space_ok;
    logic      in_fire;

    assign s_tready = space_ok;
    assign in_fire  = s_tvalid && s_tready;

    // Lexer state and token generation.
    cstk_scan #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .MAX_TEXT    (MAX_TEXT)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_byte  (s_tdata),
        .in_end   (s_tuser),
        .push_out (push)
    );

    // Output queue decouples the two sides.
    cstk_tokq u_tokq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_in    (push),
        .space_ok   (space_ok),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head_tok   (head)
    );

    // Pack the head token into the output word.
    assign m_tdata = {4'd0, head.length, head.offset, head.line, head.kind};
    assign m_tlast = head.last;

endmodule

`default_nettype wire

// ===== rtl/cstk_scan.sv =====
// Scanner core: holds the lexer mode, line and offset counters and the
// pending token, and produces up to two tokens per accepted word.
// Depends on cstk_pkg.
`default_nettype none

module cstk_scan
    import cstk_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 16,
    parameter int MAX_TEXT    = 127
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_end,
    output tok_push_t       push_out
);

    localparam int RUN_BITS = $clog2(MAX_TEXT + 1);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    localparam logic [39:0] KW_INT   = 40'h0000696E74;
    localparam logic [39:0] KW_CHAR  = 40'h0063686172;
    localparam logic [39:0] KW_FLOAT = 40'h666C6F6174;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_LINECOM, M_BLOCK, M_BLOCKSTAR, M_PRE,
        M_IDENT, M_NUM, M_CHQ, M_CHC, M_STR
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [LINE_BITS-1:0]   start_line_reg, start_line_next;
    logic [OFFSET_BITS-1:0] start_offset_reg, start_offset_next;
    logic [RUN_BITS-1:0]    run_reg, run_next;
    logic [39:0]            prefix_reg, prefix_next;

    tok_t flush_tok, second_tok;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // One-byte operators; anything else is an unknown byte.
    function automatic tok_kind_t op_kind(input logic [7:0] c);
        tok_kind_t k;
        k = K_UNKNOWN;
        case (c)
            8'h3D:   k = K_ASSIGN;
            8'h3B:   k = K_SEMI;
            8'h2C:   k = K_COMMA;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    // Next-state and token logic for the word on the input.
    always_comb begin
        logic                  eos;
        logic                  again;
        logic                  flush_v;
        logic                  second_v;
        logic [RUN_BITS-1:0]   run_ext;
        logic [RUN_BITS-1:0]   flush_len;
        logic [LINE_BITS-1:0]  line_inc;
        tok_kind_t             pend_kind;
        tok_kind_t             second_kind;
        logic [6:0]            second_len;

        mode_next         = mode_reg;
        line_next         = line_reg;
        offset_next       = offset_reg;
        start_line_next   = start_line_reg;
        start_offset_next = start_offset_reg;
        run_next          = run_reg;
        prefix_next       = prefix_reg;

        eos         = in_end || (in_byte == 8'h00);
        again       = 1'b0;
        flush_v     = 1'b0;
        second_v    = 1'b0;
        second_kind = K_UNKNOWN;
        second_len  = 7'd1;
        run_ext     = (run_reg < RUN_BITS'(MAX_TEXT)) ? run_reg + 1'b1 : run_reg;
        flush_len   = run_reg;
        line_inc    = (line_reg != '1) ? line_reg + 1'b1 : line_reg;

        // Kind of the token now pending, if any.
        case (mode_reg)
            M_SLASH: pend_kind = K_SLASH;
            M_PRE:   pend_kind = K_PREPROC;
            M_IDENT: begin
                if (run_reg == RUN_BITS'(3) && prefix_reg == KW_INT) begin
                    pend_kind = K_INT;
                end else if (run_reg == RUN_BITS'(5) && prefix_reg == KW_FLOAT) begin
                    pend_kind = K_FLOAT;
                end else if (run_reg == RUN_BITS'(4) && prefix_reg == KW_CHAR) begin
                    pend_kind = K_CHAR;
                end else begin
                    pend_kind = K_IDENT;
                end
            end
            M_NUM:        pend_kind = K_NUMBER;
            M_CHQ, M_CHC: pend_kind = K_CHARCONST;
            M_STR:        pend_kind = K_STRING;
            default:      pend_kind = K_EOF;
        endcase

        if (eos) begin
            // End of source: flush, emit EOF, return to the reset state.
            flush_v           = (pend_kind != K_EOF);
            second_v          = 1'b1;
            second_kind       = K_EOF;
            second_len        = 7'd0;
            mode_next         = M_IDLE;
            line_next         = LINE_BITS'(1);
            offset_next       = '0;
            start_line_next   = LINE_BITS'(1);
            start_offset_next = '0;
            run_next          = '0;
            prefix_next       = '0;
        end else begin
            unique case (mode_reg)
                M_SLASH: begin
                    if (in_byte == CH_SLASH) begin
                        mode_next = M_LINECOM;
                    end else if (in_byte == CH_STAR) begin
                        mode_next = M_BLOCK;
                    end else begin
                        flush_v = 1'b1;
                        again   = 1'b1;
                    end
                end
                M_LINECOM: begin
                    if (in_byte == CH_LF) begin
                        line_next = line_inc;
                        mode_next = M_IDLE;
                    end
                end
                M_BLOCK: begin
                    if (in_byte == CH_STAR) begin
                        mode_next = M_BLOCKSTAR;
                    end else if (in_byte == CH_LF) begin
                        line_next = line_inc;
                    end
                end
                M_BLOCKSTAR: begin
                    if (in_byte == CH_SLASH) begin
                        mode_next = M_IDLE;
                    end else if (in_byte != CH_STAR) begin
                        if (in_byte == CH_LF) begin
                            line_next = line_inc;
                        end
                        mode_next = M_BLOCK;
                    end
                end
                M_PRE: begin
                    if (in_byte == CH_LF) begin
                        flush_v = 1'b1;
                        again   = 1'b1;
                    end else begin
                        run_next = run_ext;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == CH_USCORE) begin
                        run_next = run_ext;
                        if (run_reg < RUN_BITS'(5)) begin
                            prefix_next = {prefix_reg[31:0], in_byte};
                        end
                    end else begin
                        flush_v = 1'b1;
                        again   = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_digit(in_byte) || in_byte == CH_DOT) begin
                        run_next = run_ext;
                    end else begin
                        flush_v = 1'b1;
                        again   = 1'b1;
                    end
                end
                M_CHQ: begin
                    run_next  = run_ext;
                    mode_next = M_CHC;
                end
                M_CHC: begin
                    flush_v = 1'b1;
                    if (in_byte == CH_QUOTE) begin
                        run_next  = run_ext;
                        flush_len = run_ext;
                    end else begin
                        again = 1'b1;
                    end
                end
                M_STR: begin
                    run_next = run_ext;
                    if (in_byte == CH_DQUOTE) begin
                        flush_v   = 1'b1;
                        flush_len = run_ext;
                    end
                end
                default: begin
                    again = 1'b1;
                end
            endcase

            if (flush_v) begin
                mode_next = M_IDLE;
            end

            // Byte seen between tokens, either fresh or handed back.
            if (again) begin
                mode_next = M_IDLE;
                if (in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_CR) begin
                    mode_next = M_IDLE;
                end else if (in_byte == CH_LF) begin
                    line_next = line_inc;
                end else if (in_byte == CH_SLASH || in_byte == CH_HASH ||
                             in_byte == CH_QUOTE || in_byte == CH_DQUOTE ||
                             is_alpha(in_byte) || in_byte == CH_USCORE ||
                             is_digit(in_byte)) begin
                    start_line_next   = line_reg;
                    start_offset_next = offset_reg;
                    run_next          = RUN_BITS'(1);
                    prefix_next       = '0;
                    if (in_byte == CH_SLASH) begin
                        mode_next = M_SLASH;
                    end else if (in_byte == CH_HASH) begin
                        mode_next = M_PRE;
                    end else if (in_byte == CH_QUOTE) begin
                        mode_next = M_CHQ;
                    end else if (in_byte == CH_DQUOTE) begin
                        mode_next = M_STR;
                    end else if (is_digit(in_byte)) begin
                        mode_next = M_NUM;
                    end else begin
                        mode_next   = M_IDENT;
                        prefix_next = {32'd0, in_byte};
                    end
                end else begin
                    second_v    = 1'b1;
                    second_kind = op_kind(in_byte);
                end
            end

            offset_next = (offset_reg != '1) ? offset_reg + 1'b1 : offset_reg;
        end

        // Assemble the tokens; the later one carries the end-of-run mark.
        flush_tok.kind    = pend_kind;
        flush_tok.line    = 16'(32'(start_line_reg));
        flush_tok.offset  = 16'(32'(start_offset_reg));
        flush_tok.length  = 7'(32'(flush_len));
        flush_tok.last    = !second_v;

        second_tok.kind   = second_kind;
        second_tok.line   = 16'(32'(line_reg));
        second_tok.offset = 16'(32'(offset_reg));
        second_tok.length = second_len;
        second_tok.last   = 1'b1;

        push_out.count  = in_fire ? ({1'b0, flush_v} + {1'b0, second_v}) : 2'd0;
        push_out.first  = flush_v ? flush_tok : second_tok;
        push_out.second = second_tok;
    end

    // Scanner state, advanced once per accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= M_IDLE;
            line_reg         <= LINE_BITS'(1);
            offset_reg       <= '0;
            start_line_reg   <= LINE_BITS'(1);
            start_offset_reg <= '0;
            run_reg          <= '0;
            prefix_reg       <= '0;
        end else if (in_fire) begin
            mode_reg         <= mode_next;
            line_reg         <= line_next;
            offset_reg       <= offset_next;
            start_line_reg   <= start_line_next;
            start_offset_reg <= start_offset_next;
            run_reg          <= run_next;
            prefix_reg       <= prefix_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cstk_tokq.sv =====
// Four-entry token queue between the scanner and the result channel.
// Takes up to two tokens a cycle, hands out one from the head slot.
// Depends on cstk_pkg.
`default_nettype none

module cstk_tokq
    import cstk_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  tok_push_t      push_in,
    output logic           space_ok,
    output logic           head_valid,
    input  wire logic      head_ready,
    output tok_t           head_tok
);

    localparam int DEPTH = 4;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    tok_t                slot_reg  [DEPTH];
    tok_t                slot_next [DEPTH];
    logic [CNT_BITS-1:0] count_reg, count_next;

    logic pop;

    assign head_valid = (count_reg != '0);
    assign head_tok   = slot_reg[0];
    assign pop        = head_valid && head_ready;
    // Room for the worst case of two new tokens.
    assign space_ok   = (count_reg <= CNT_BITS'(DEPTH - 2));

    // Shift on pop, then append the new tokens behind the survivors.
    always_comb begin
        logic [CNT_BITS-1:0] base;
        tok_t                shifted [DEPTH];

        base = count_reg - (pop ? CNT_BITS'(1) : CNT_BITS'(0));
        for (int i = 0; i < DEPTH - 1; i++) begin
            shifted[i] = pop ? slot_reg[i + 1] : slot_reg[i];
        end
        shifted[DEPTH - 1] = slot_reg[DEPTH - 1];

        for (int i = 0; i < DEPTH; i++) begin
            slot_next[i] = shifted[i];
            if (push_in.count != 2'd0 && CNT_BITS'(i) == base) begin
                slot_next[i] = push_in.first;
            end
            if (push_in.count == 2'd2 && CNT_BITS'(i) == base + CNT_BITS'(1)) begin
                slot_next[i] = push_in.second;
            end
        end
        count_next = base + CNT_BITS'(push_in.count);
    end

    // Slot payloads need no reset; the fill count does.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire
